FILE: hdl/irc_tok_pkg.sv
// Shared types and constants for the IRC line tokenizer.
package irc_tok_pkg;

   localparam int MAX_PARAMS_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [2:0] ROLE_PREFIX  = 3'd0;
   localparam logic [2:0] ROLE_MIDDLE  = 3'd1;
   localparam logic [2:0] ROLE_TRAIL   = 3'd2;
   localparam logic [2:0] ROLE_SEP     = 3'd3;
   localparam logic [2:0] ROLE_SUMMARY = 3'd4;

   typedef enum logic [2:0] {
      MODE_LINE_START = 3'd0,
      MODE_PREFIX     = 3'd1,
      MODE_TOKSTART   = 3'd2,
      MODE_INTOKEN    = 3'd3,
      MODE_TRAILING   = 3'd4
   } mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       line_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] role;
      logic [3:0] param_index;
      logic       param_closed;
      logic       run_last;
      logic [4:0] param_count;
      logic       prefix_unterminated;
      logic       too_many_params;
   } rsp_type;

   // one accepted byte: its own beat, plus the summary beat on a line's last byte
   typedef struct packed {
      rsp_type first;
      logic    has_summary;
      rsp_type summary;
   } qent_type;

endpackage

FILE: hdl/irc_tok_classify.sv
// Byte classifier: next parse state and the result beats for one byte.
module irc_tok_classify #(
   parameter int MAX_PARAMS = irc_tok_pkg::MAX_PARAMS_DEFAULT,
   localparam int CW = $clog2(MAX_PARAMS + 1)
) (
   input  irc_tok_pkg::req_type  req,
   input  irc_tok_pkg::mode_type mode,
   input  logic [CW-1:0]         cnt,
   input  logic                  ovf,
   output irc_tok_pkg::mode_type mode_in,
   output logic [CW-1:0]         cnt_in,
   output logic                  ovf_in,
   output irc_tok_pkg::qent_type entry
);

   localparam logic [CW-1:0] MAXC  = CW'(MAX_PARAMS);
   localparam logic [CW-1:0] MAXC1 = CW'(MAX_PARAMS - 1);

   logic                  is_colon;
   logic                  is_space;
   logic                  open_full;
   logic [CW-1:0]         open_idx;
   logic [CW-1:0]         open_cnt;
   logic [CW-1:0]         cur_idx;
   logic [CW-1:0]         sum_cur;
   logic                  tok;
   irc_tok_pkg::mode_type mode_step;
   logic [CW-1:0]         cnt_step;
   logic                  ovf_step;
   logic [2:0]            role;
   logic [CW-1:0]         idx;
   logic                  closed;
   logic                  sum_closed;
   logic                  sum_unterm;

   assign is_colon  = req.data_byte == irc_tok_pkg::CHAR_COLON;
   assign is_space  = req.data_byte == irc_tok_pkg::CHAR_SPACE;
   assign open_full = cnt >= MAXC;
   assign open_idx  = open_full ? MAXC1 : cnt;
   assign open_cnt  = open_full ? MAXC : cnt + CW'(1);
   assign cur_idx   = (cnt == '0) ? '0 : cnt - CW'(1);

   always_comb begin
      mode_step = mode;
      cnt_step  = cnt;
      ovf_step  = ovf;
      role      = irc_tok_pkg::ROLE_SEP;
      idx       = '0;
      closed    = 1'b0;
      tok       = 1'b0;
      unique case (mode)
         irc_tok_pkg::MODE_LINE_START: begin
            if (is_colon) begin
               mode_step = irc_tok_pkg::MODE_PREFIX;
            end else begin
               tok = 1'b1;
            end
         end
         irc_tok_pkg::MODE_PREFIX: begin
            if (is_space) begin
               mode_step = irc_tok_pkg::MODE_TOKSTART;
            end else begin
               role = irc_tok_pkg::ROLE_PREFIX;
            end
         end
         irc_tok_pkg::MODE_INTOKEN: begin
            idx = cur_idx;
            if (is_space) begin
               closed    = 1'b1;
               mode_step = irc_tok_pkg::MODE_TOKSTART;
            end else if (is_colon) begin
               closed    = 1'b1;
               cnt_step  = open_cnt;
               ovf_step  = ovf | open_full;
               mode_step = irc_tok_pkg::MODE_TRAILING;
            end else begin
               role = irc_tok_pkg::ROLE_MIDDLE;
            end
         end
         irc_tok_pkg::MODE_TRAILING: begin
            idx  = cur_idx;
            role = irc_tok_pkg::ROLE_TRAIL;
         end
         default: begin
            tok = 1'b1;
         end
      endcase
      if (tok) begin
         idx      = open_idx;
         cnt_step = open_cnt;
         ovf_step = ovf | open_full;
         if (is_space) begin
            closed    = 1'b1;
            mode_step = irc_tok_pkg::MODE_TOKSTART;
         end else if (is_colon) begin
            mode_step = irc_tok_pkg::MODE_TRAILING;
         end else begin
            role      = irc_tok_pkg::ROLE_MIDDLE;
            mode_step = irc_tok_pkg::MODE_INTOKEN;
         end
      end
   end

   assign sum_cur    = (cnt_step == '0) ? '0 : cnt_step - CW'(1);
   assign sum_closed = (mode_step == irc_tok_pkg::MODE_INTOKEN) ||
                       (mode_step == irc_tok_pkg::MODE_TRAILING);
   assign sum_unterm = mode_step == irc_tok_pkg::MODE_PREFIX;

   always_comb begin
      entry.first.out_byte            = req.data_byte;
      entry.first.role                = role;
      entry.first.param_index         = 4'(idx);
      entry.first.param_closed        = closed;
      entry.first.run_last            = ~req.line_last;
      entry.first.param_count         = '0;
      entry.first.prefix_unterminated = 1'b0;
      entry.first.too_many_params     = ovf_step;
      entry.has_summary               = req.line_last;
      entry.summary.out_byte            = '0;
      entry.summary.role                = irc_tok_pkg::ROLE_SUMMARY;
      entry.summary.param_index         = sum_closed ? 4'(sum_cur) : '0;
      entry.summary.param_closed        = sum_closed;
      entry.summary.run_last            = 1'b1;
      entry.summary.param_count         = sum_unterm ? '0 : 5'(cnt_step);
      entry.summary.prefix_unterminated = sum_unterm;
      entry.summary.too_many_params     = ovf_step;
   end

   // after a line's last byte everything returns to line start
   always_comb begin
      if (req.line_last) begin
         mode_in = irc_tok_pkg::MODE_LINE_START;
         cnt_in  = '0;
         ovf_in  = 1'b0;
      end else begin
         mode_in = mode_step;
         cnt_in  = cnt_step;
         ovf_in  = ovf_step;
      end
   end

endmodule

FILE: hdl/irc_tok_queue.sv
// Result queue: holds classified bytes and sends one or two beats per entry.
module irc_tok_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  irc_tok_pkg::qent_type push_entry,
   output logic                  push_ready,
   output logic                  rsp_valid,
   output irc_tok_pkg::rsp_type  rsp_data,
   input  logic                  rsp_ready
);

   localparam int DEPTH = irc_tok_pkg::QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(DEPTH + 1);

   irc_tok_pkg::qent_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          second_ff, second_in;
   logic          push;
   logic          pop;
   irc_tok_pkg::qent_type head;

   assign head       = mem_ff[rd_ptr_ff];
   assign push_ready = count_ff < NW'(DEPTH);
   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = second_ff ? head.summary : head.first;
   assign push       = push_valid & push_ready;
   assign pop        = rsp_valid & rsp_ready & (~head.has_summary | second_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      second_in = second_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         second_in = 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         second_in = 1'b1;
      end
      count_in = count_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         second_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hdl/irc_line_tokenizer_core.sv
// Top level of the IRC line tokenizer: parse state registers and result queue.
//
// Tags each byte of an IRC message line as prefix, middle, trailing or
// separator text and tracks parameter indexes; no text is stored. A byte is
// taken every cycle while the two-entry result queue has room; each byte gives
// one result beat, and the last byte of a line gives a second, the line
// summary, so such a byte holds the result side for two beats. The mode,
// parameter counter and overflow flag update in the cycle a byte is taken, and
// its results can leave on the next cycle. Parameters past MAX_PARAMS set the
// overflow flag and share index MAX_PARAMS-1.
module irc_line_tokenizer_core #(
   parameter int MAX_PARAMS = irc_tok_pkg::MAX_PARAMS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  irc_tok_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output irc_tok_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_PARAMS + 1);

   irc_tok_pkg::mode_type mode_ff, mode_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;
   irc_tok_pkg::qent_type entry;
   logic                  req_beat;

   assign req_beat = req_valid & req_ready;

   irc_tok_classify #(
      .MAX_PARAMS(MAX_PARAMS)
   ) u_classify (
      .req     (req_data),
      .mode    (mode_ff),
      .cnt     (cnt_ff),
      .ovf     (ovf_ff),
      .mode_in (mode_in),
      .cnt_in  (cnt_in),
      .ovf_in  (ovf_in),
      .entry   (entry)
   );

   irc_tok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_entry (entry),
      .push_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_ready  (rsp_ready)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= irc_tok_pkg::MODE_LINE_START;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (req_beat) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
      end
   end

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_data.line_last |=>
         mode_ff == irc_tok_pkg::MODE_LINE_START && cnt_ff == '0 && !ovf_ff)
      else $error("parse state not cleared after line end");

   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_PARAMS))
      else $error("parameter counter beyond limit");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.role == irc_tok_pkg::ROLE_SUMMARY |-> rsp_data.run_last)
      else $error("summary beat not marked last");

   a_unterm_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.prefix_unterminated |->
         rsp_data.param_count == '0 && rsp_data.role == irc_tok_pkg::ROLE_SUMMARY)
      else $error("void line reports parameters");

endmodule
